// ----- hw/rtl/eba_pkg.sv -----
// Shared types and constants for the EEPROM byte access master.
// No dependencies; every other file but eba_stream_if refers to this package by scoped names.
`timescale 1ns / 1ps

package eba_pkg;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_US = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY_US  = 2'd2;

  // Reset values of the configuration registers
  localparam logic [15:0] TICKS_PER_US_RST = 16'd72;
  localparam logic [6:0]  DEVICE_ADDR_RST  = 7'd80;
  localparam logic [15:0] RECOVERY_US_RST  = 16'd10000;

  // One clock tick of the bus sequencer
  typedef struct packed {
    logic       start_request;
    logic       operation;
    logic [7:0] word_address;
    logic [7:0] write_data;
    logic       sda_in;
  } item_t;

  // Line levels and status after one tick
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_enable;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_missing;
  } result_t;

  typedef struct packed {
    logic [15:0] ticks_per_microsecond;
    logic [6:0]  device_address;
    logic [15:0] write_recovery_us;
  } cfg_t;

endpackage

// ----- hw/rtl/eba_stream_if.sv -----
// Valid/ready stream channel carrying one payload of type T.
// Depends on nothing; payload types come from eba_pkg at the instance.
`timescale 1ns / 1ps

interface eba_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/i2c_eeprom_byte_access_master.sv -----
// Top level of the EEPROM byte access master: configuration registers, front queue,
// sequencer. Depends on eba_pkg, eba_stream_if, eba_front and eba_seq.
`timescale 1ns / 1ps

// Usage:
//   cmd carries one clock tick of the bus sequencer per transfer: a start strobe,
//   the operation (0 read, 1 write), word address, write data and the sampled SDA
//   level. rsp returns exactly one transfer per cmd transfer, in order: SCL level,
//   SDA level and enable, busy, a one-tick done pulse, the last byte read and the
//   missing-ack flag.
//   A random byte access runs start, device address, word address, then the data
//   byte and stop for a write (followed by write_recovery_us of busy time), or a
//   repeated start, device address with read set, 8 bits in, NACK and stop for a
//   read. Phase times count in units of ticks_per_microsecond ticks.
//   A cmd transfer passes through the queue and then the result register on its way to rsp.
//   Throughput is one transfer per cycle while rsp does not stall; the sequencer
//   then steps once per cycle from the queue.
//   When rsp stalls, the result register holds, the sequencer stops and the
//   queue (QUEUE_DEPTH entries) fills before cmd.ready drops.
//   Reset empties the queue and result register, returns the sequencer to idle
//   with both lines high and loads the configuration reset values.
//   cfg_we writes cfg_data into register cfg_index (0 ticks per microsecond,
//   1 device address, 2 write recovery time); write only while idle.

module i2c_eeprom_byte_access_master #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [eba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [eba_pkg::CFG_DATA_W-1:0]  cfg_data,
  eba_stream_if.sink                      cmd,
  eba_stream_if.source                    rsp
);

  eba_pkg::cfg_t  cfg;
  eba_pkg::item_t pop_item;
  logic           pop_valid;
  logic           pop_ready;

  // Configuration registers: take effect on the next tick
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ticks_per_microsecond <= eba_pkg::TICKS_PER_US_RST;
      cfg.device_address        <= eba_pkg::DEVICE_ADDR_RST;
      cfg.write_recovery_us     <= eba_pkg::RECOVERY_US_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        eba_pkg::CFG_TICKS_PER_US: cfg.ticks_per_microsecond <= cfg_data;
        eba_pkg::CFG_DEVICE_ADDR:  cfg.device_address        <= cfg_data[6:0];
        eba_pkg::CFG_RECOVERY_US:  cfg.write_recovery_us     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front: queue the incoming ticks
  eba_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .pop_item  (pop_item),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready)
  );

  // Back: step the bus sequencer and hold the result
  eba_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_item  (pop_item),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .rsp       (rsp)
  );

endmodule

// ----- hw/rtl/eba_front.sv -----
// Front end: takes input transfers into a short queue that feeds the sequencer.
// Depends on eba_pkg and eba_stream_if.
`timescale 1ns / 1ps

module eba_front #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  eba_stream_if.sink     cmd,
  output eba_pkg::item_t pop_item,
  output logic           pop_valid,
  input  logic           pop_ready
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  eba_pkg::item_t   queue [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign cmd.ready = (count != FULL_CNT);
  assign push      = cmd.valid && cmd.ready;
  assign pop_valid = (count != '0);
  assign pop       = pop_valid && pop_ready;
  assign pop_item  = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= cmd.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/eba_seq.sv -----
// Back end: the bus sequencer, one tick per queued item, and the result register.
// Depends on eba_pkg and eba_stream_if.
`timescale 1ns / 1ps

module eba_seq (
  input  logic           clk,
  input  logic           rst,
  input  eba_pkg::cfg_t  cfg,
  input  eba_pkg::item_t pop_item,
  input  logic           pop_valid,
  output logic           pop_ready,
  eba_stream_if.source   rsp
);

  localparam logic [4:0] PH_IDLE      = 5'd0;
  localparam logic [4:0] PH_START_HI  = 5'd1;
  localparam logic [4:0] PH_START_LO  = 5'd2;
  localparam logic [4:0] PH_BYTE0     = 5'd3;
  localparam logic [4:0] PH_BYTE1     = 5'd7;
  localparam logic [4:0] PH_BYTE2     = 5'd11;
  localparam logic [4:0] PH_BYTE3     = 5'd15;
  localparam logic [4:0] PH_BYTE_END  = 5'd18;
  localparam logic [4:0] PH_RSTART_HI = 5'd19;
  localparam logic [4:0] PH_RSTART_LO = 5'd20;
  localparam logic [4:0] PH_RBIT_LO   = 5'd21;
  localparam logic [4:0] PH_RBIT_HI   = 5'd22;
  localparam logic [4:0] PH_NACK_LO   = 5'd23;
  localparam logic [4:0] PH_NACK_HI   = 5'd24;
  localparam logic [4:0] PH_STOP_LO   = 5'd25;
  localparam logic [4:0] PH_STOP_HI   = 5'd26;
  localparam logic [4:0] PH_RECOVER   = 5'd27;

  logic [4:0]  phase, phase_next;
  logic [3:0]  bit_count, bit_count_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [15:0] tick_count, tick_count_next;
  logic [15:0] us_count, us_count_next;
  logic        lat_op, lat_op_next;
  logic [7:0]  lat_addr, lat_addr_next;
  logic [7:0]  lat_data, lat_data_next;
  logic [7:0]  received_byte, received_byte_next;
  logic        nack_seen, nack_seen_next;

  logic        advance;
  logic        out_valid;
  eba_pkg::result_t out_data;
  eba_pkg::result_t res;

  // Comb working values
  logic        done;
  logic        go;
  logic [4:0]  go_phase;
  logic [15:0] tpu;
  logic [15:0] tick_inc;
  logic [15:0] us_inc;
  logic [15:0] plen;
  logic [4:0]  boff;
  logic [1:0]  bk;
  logic [1:0]  bsub;
  logic [3:0]  bit_inc;
  logic [7:0]  shift_in;
  logic [4:0]  dboff;
  logic        scl_d, sda_d, en_d;

  assign advance   = pop_valid && (!out_valid || rsp.ready);
  assign pop_ready = !out_valid || rsp.ready;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  // Length of the current phase in microsecond units
  always_comb begin
    plen = '0;
    if (phase inside {[PH_BYTE0:PH_BYTE_END]} || phase == PH_RBIT_LO ||
        phase == PH_RBIT_HI) begin
      plen = 16'd1;
    end else begin
      case (phase)
        PH_START_HI, PH_START_LO, PH_RSTART_HI, PH_RSTART_LO,
        PH_STOP_LO, PH_STOP_HI: plen = 16'd4;
        PH_NACK_LO, PH_NACK_HI:  plen = 16'd2;
        PH_RECOVER:              plen = cfg.write_recovery_us;
        default:                 plen = '0;
      endcase
    end
  end

  always_comb begin
    phase_next         = phase;
    bit_count_next     = bit_count;
    shift_byte_next    = shift_byte;
    tick_count_next    = tick_count;
    us_count_next      = us_count;
    lat_op_next        = lat_op;
    lat_addr_next      = lat_addr;
    lat_data_next      = lat_data;
    received_byte_next = received_byte;
    nack_seen_next     = nack_seen;
    done     = 1'b0;
    go       = 1'b0;
    go_phase = PH_IDLE;
    tpu      = (cfg.ticks_per_microsecond == '0) ? 16'd1 : cfg.ticks_per_microsecond;
    tick_inc = tick_count + 16'd1;
    us_inc   = us_count + 16'd1;
    boff     = phase - PH_BYTE0;
    bk       = boff[3:2];
    bsub     = boff[1:0];
    bit_inc  = bit_count + 4'd1;
    shift_in = {shift_byte[6:0], pop_item.sda_in};

    if (phase == PH_IDLE) begin
      if (pop_item.start_request) begin
        lat_op_next    = pop_item.operation;
        lat_addr_next  = pop_item.word_address;
        lat_data_next  = pop_item.write_data;
        nack_seen_next = 1'b0;
        go             = 1'b1;
        go_phase       = PH_START_HI;
      end
    end else begin
      tick_count_next = tick_inc;
      if (tick_inc >= tpu) begin
        tick_count_next = '0;
        us_count_next   = us_inc;
        if (us_inc >= plen) begin
          go = 1'b1;
          if (phase inside {[PH_BYTE0:PH_BYTE_END]}) begin
            case (bsub)
              2'd0, 2'd2: go_phase = phase + 5'd1;
              2'd1: begin
                shift_byte_next = {shift_byte[6:0], 1'b0};
                if (bit_inc >= 4'd8) begin
                  bit_count_next = '0;
                  go_phase       = phase + 5'd1;
                end else begin
                  bit_count_next = bit_inc;
                  go_phase       = phase - 5'd1;
                end
              end
              default: begin
                // Ack slot: record a high ack, carry on regardless
                if (pop_item.sda_in) begin
                  nack_seen_next = 1'b1;
                end
                case (bk)
                  2'd0: begin
                    shift_byte_next = lat_addr;
                    bit_count_next  = '0;
                    go_phase        = PH_BYTE1;
                  end
                  2'd1: begin
                    if (lat_op) begin
                      shift_byte_next = lat_data;
                      bit_count_next  = '0;
                      go_phase        = PH_BYTE2;
                    end else begin
                      go_phase = PH_RSTART_HI;
                    end
                  end
                  2'd2: go_phase = PH_STOP_LO;
                  default: begin
                    bit_count_next  = '0;
                    shift_byte_next = '0;
                    go_phase        = PH_RBIT_LO;
                  end
                endcase
              end
            endcase
          end else begin
            case (phase)
              PH_START_HI: go_phase = PH_START_LO;
              PH_START_LO: begin
                shift_byte_next = {cfg.device_address, 1'b0};
                bit_count_next  = '0;
                go_phase        = PH_BYTE0;
              end
              PH_RSTART_HI: go_phase = PH_RSTART_LO;
              PH_RSTART_LO: begin
                shift_byte_next = {cfg.device_address, 1'b1};
                bit_count_next  = '0;
                go_phase        = PH_BYTE3;
              end
              PH_RBIT_LO: go_phase = PH_RBIT_HI;
              PH_RBIT_HI: begin
                shift_byte_next = shift_in;
                if (bit_inc >= 4'd8) begin
                  received_byte_next = shift_in;
                  bit_count_next     = '0;
                  go_phase           = PH_NACK_LO;
                end else begin
                  bit_count_next = bit_inc;
                  go_phase       = PH_RBIT_LO;
                end
              end
              PH_NACK_LO: go_phase = PH_NACK_HI;
              PH_NACK_HI: go_phase = PH_STOP_LO;
              PH_STOP_LO: go_phase = PH_STOP_HI;
              PH_STOP_HI: begin
                if (lat_op && cfg.write_recovery_us != '0) begin
                  go_phase = PH_RECOVER;
                end else begin
                  go_phase = PH_IDLE;
                  done     = 1'b1;
                end
              end
              PH_RECOVER: begin
                go_phase = PH_IDLE;
                done     = 1'b1;
              end
              default: go_phase = PH_IDLE;
            endcase
          end
        end
      end
    end

    if (go) begin
      phase_next      = go_phase;
      tick_count_next = '0;
      us_count_next   = '0;
    end
  end

  // Line levels for the phase being entered
  always_comb begin
    scl_d = 1'b1;
    sda_d = 1'b1;
    en_d  = 1'b1;
    dboff = phase_next - PH_BYTE0;
    if (phase_next inside {[PH_BYTE0:PH_BYTE_END]}) begin
      if (dboff[1:0] == 2'd1 || dboff[1:0] == 2'd2) begin
        scl_d = 1'b0;
      end
      if (!dboff[1]) begin
        sda_d = shift_byte_next[7];
      end else begin
        en_d = 1'b0;
      end
    end else begin
      case (phase_next)
        PH_START_LO, PH_RSTART_LO, PH_STOP_LO: sda_d = 1'b0;
        PH_RBIT_LO: begin
          scl_d = 1'b0;
          en_d  = 1'b0;
        end
        PH_RBIT_HI: en_d  = 1'b0;
        PH_NACK_LO: scl_d = 1'b0;
        default: ;
      endcase
    end

    res.scl_level   = scl_d;
    res.sda_level   = en_d ? sda_d : 1'b1;
    res.sda_enable  = en_d;
    res.busy_res    = (phase_next != PH_IDLE);
    res.done_res    = done;
    res.read_byte   = received_byte_next;
    res.ack_missing = nack_seen_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      bit_count     <= '0;
      shift_byte    <= '0;
      tick_count    <= '0;
      us_count      <= '0;
      lat_op        <= 1'b0;
      lat_addr      <= '0;
      lat_data      <= '0;
      received_byte <= '0;
      nack_seen     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (advance) begin
        phase         <= phase_next;
        bit_count     <= bit_count_next;
        shift_byte    <= shift_byte_next;
        tick_count    <= tick_count_next;
        us_count      <= us_count_next;
        lat_op        <= lat_op_next;
        lat_addr      <= lat_addr_next;
        lat_data      <= lat_data_next;
        received_byte <= received_byte_next;
        nack_seen     <= nack_seen_next;
        out_valid     <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= res;
    end
  end

endmodule

// ----- tb/i2c_eeprom_byte_access_master_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for i2c_eeprom_byte_access_master: one bus tick per cmd transfer,
// every rsp transfer checked against a sequencer model kept inside the bench.
// Depends on eba_pkg, eba_stream_if and the block's RTL.

module i2c_eeprom_byte_access_master_tb;

  localparam int CLK_HALF_NS      = 4;
  localparam int TIMEOUT_NS       = 10_000_000;
  localparam int SETTLE_CYCLES    = 8;
  localparam int RANDOM_TICKS     = 100;
  localparam int LONG_HOLD        = 400;
  localparam int ACCESS_LIMIT     = 100_000;
  localparam int RESET_RATE_TICKS = 300;
  localparam int RECOVERY_TICKS   = 150;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Sequencer phases; the four slots of byte k sit at SEQ_BYTE0 + 4k + slot
  localparam logic [4:0] SEQ_IDLE      = 5'd0;
  localparam logic [4:0] SEQ_START_HI  = 5'd1;
  localparam logic [4:0] SEQ_START_LO  = 5'd2;
  localparam logic [4:0] SEQ_BYTE0     = 5'd3;
  localparam logic [4:0] SEQ_BYTE_END  = 5'd18;
  localparam logic [4:0] SEQ_RSTART_HI = 5'd19;
  localparam logic [4:0] SEQ_RSTART_LO = 5'd20;
  localparam logic [4:0] SEQ_RBIT_LO   = 5'd21;
  localparam logic [4:0] SEQ_RBIT_HI   = 5'd22;
  localparam logic [4:0] SEQ_NACK_LO   = 5'd23;
  localparam logic [4:0] SEQ_NACK_HI   = 5'd24;
  localparam logic [4:0] SEQ_STOP_LO   = 5'd25;
  localparam logic [4:0] SEQ_STOP_HI   = 5'd26;
  localparam logic [4:0] SEQ_RECOVER   = 5'd27;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_we;
  logic [eba_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [eba_pkg::CFG_DATA_W-1:0] cfg_data;

  eba_stream_if #(.T(eba_pkg::item_t))   cmd_if ();
  eba_stream_if #(.T(eba_pkg::result_t)) rsp_if ();

  i2c_eeprom_byte_access_master u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd_if),
    .rsp       (rsp_if)
  );

  always #CLK_HALF_NS clk = ~clk;

  // ---------------------------------------------------------------------------
  // Sequencer model: configuration copy and state, advanced once per cmd transfer
  // ---------------------------------------------------------------------------
  logic [15:0] cfg_tpu;
  logic [6:0]  cfg_device;
  logic [15:0] cfg_recovery_us;

  logic [4:0]  seq_phase;
  logic [3:0]  seq_bits;
  logic [7:0]  seq_shift;
  logic [15:0] seq_ticks;
  logic [15:0] seq_units;
  logic        lat_op;
  logic [7:0]  lat_addr;
  logic [7:0]  lat_data;
  logic [7:0]  rx_byte;
  logic        nack_seen;

  eba_pkg::result_t predicted_lines[$];

  // Stimulus and handshake knobs, shared by the test tasks
  int burst_left;
  int gap_max;
  int stall_pct;
  int hold_left;
  int busy_start_pct;
  int ticks_sent;
  int mismatches;

  function automatic logic in_byte_slot(input logic [4:0] p);
    return p >= SEQ_BYTE0 && p <= SEQ_BYTE_END;
  endfunction

  function automatic void enter_phase(input logic [4:0] p);
    seq_phase = p;
    seq_ticks = '0;
    seq_units = '0;
  endfunction

  function automatic void load_byte(input int k, input logic [7:0] value);
    seq_shift = value;
    seq_bits  = '0;
    enter_phase(5'(SEQ_BYTE0 + 4 * k));
  endfunction

  // Length of a phase in microsecond units
  function automatic logic [15:0] phase_units(input logic [4:0] p);
    if (in_byte_slot(p) || p == SEQ_RBIT_LO || p == SEQ_RBIT_HI) return 16'd1;
    case (p)
      SEQ_START_HI, SEQ_START_LO, SEQ_RSTART_HI, SEQ_RSTART_LO,
      SEQ_STOP_LO, SEQ_STOP_HI:  return 16'd4;
      SEQ_NACK_LO, SEQ_NACK_HI:  return 16'd2;
      SEQ_RECOVER:               return cfg_recovery_us;
      default:                   return 16'd0;
    endcase
  endfunction

  // Close the current phase; returns 1 when the transaction ends with done
  function automatic logic end_of_phase(input logic sda);
    logic [4:0] rel;
    int         k;
    logic [1:0] slot;
    if (in_byte_slot(seq_phase)) begin
      rel  = seq_phase - SEQ_BYTE0;
      k    = int'(rel[4:2]);
      slot = rel[1:0];
      case (slot)
        2'd0, 2'd2: enter_phase(seq_phase + 5'd1);
        2'd1: begin
          seq_bits  = seq_bits + 4'd1;
          seq_shift = seq_shift << 1;
          if (seq_bits >= 4'd8) begin
            seq_bits = '0;
            enter_phase(seq_phase + 5'd1);
          end else begin
            enter_phase(seq_phase - 5'd1);
          end
        end
        default: begin
          // ack slot: a high level is only recorded, the sequence goes on
          if (sda) nack_seen = 1'b1;
          case (k)
            0: load_byte(1, lat_addr);
            1: begin
              if (lat_op == OP_WRITE) load_byte(2, lat_data);
              else enter_phase(SEQ_RSTART_HI);
            end
            2: enter_phase(SEQ_STOP_LO);
            default: begin
              seq_bits  = '0;
              seq_shift = '0;
              enter_phase(SEQ_RBIT_LO);
            end
          endcase
        end
      endcase
      return 1'b0;
    end
    case (seq_phase)
      SEQ_START_HI:  enter_phase(SEQ_START_LO);
      SEQ_START_LO:  load_byte(0, {cfg_device, 1'b0});
      SEQ_RSTART_HI: enter_phase(SEQ_RSTART_LO);
      SEQ_RSTART_LO: load_byte(3, {cfg_device, 1'b1});
      SEQ_RBIT_LO:   enter_phase(SEQ_RBIT_HI);
      SEQ_RBIT_HI: begin
        seq_shift = {seq_shift[6:0], sda};
        seq_bits  = seq_bits + 4'd1;
        if (seq_bits >= 4'd8) begin
          rx_byte  = seq_shift;
          seq_bits = '0;
          enter_phase(SEQ_NACK_LO);
        end else begin
          enter_phase(SEQ_RBIT_LO);
        end
      end
      SEQ_NACK_LO:   enter_phase(SEQ_NACK_HI);
      SEQ_NACK_HI:   enter_phase(SEQ_STOP_LO);
      SEQ_STOP_LO:   enter_phase(SEQ_STOP_HI);
      SEQ_STOP_HI: begin
        if (lat_op == OP_WRITE && cfg_recovery_us != 16'd0) begin
          enter_phase(SEQ_RECOVER);
          return 1'b0;
        end
        enter_phase(SEQ_IDLE);
        return 1'b1;
      end
      SEQ_RECOVER: begin
        enter_phase(SEQ_IDLE);
        return 1'b1;
      end
      default:       enter_phase(SEQ_IDLE);
    endcase
    return 1'b0;
  endfunction

  // Advance the model by one tick and return the line levels and status after it
  function automatic eba_pkg::result_t predict_lines(input eba_pkg::item_t it);
    eba_pkg::result_t r;
    logic             fin;
    logic [15:0]      per_us;
    logic [4:0]       rel;
    logic             scl;
    logic             sda;
    logic             drive;
    fin = 1'b0;
    if (seq_phase == SEQ_IDLE) begin
      if (it.start_request) begin
        lat_op    = it.operation;
        lat_addr  = it.word_address;
        lat_data  = it.write_data;
        nack_seen = 1'b0;
        enter_phase(SEQ_START_HI);
      end
    end else begin
      per_us    = (cfg_tpu == 16'd0) ? 16'd1 : cfg_tpu;
      seq_ticks = seq_ticks + 16'd1;
      if (seq_ticks >= per_us) begin
        seq_ticks = '0;
        seq_units = seq_units + 16'd1;
        if (seq_units >= phase_units(seq_phase)) fin = end_of_phase(it.sda_in);
      end
    end

    scl   = 1'b1;
    sda   = 1'b1;
    drive = 1'b1;
    if (in_byte_slot(seq_phase)) begin
      rel = seq_phase - SEQ_BYTE0;
      if (rel[1:0] == 2'd1 || rel[1:0] == 2'd2) scl = 1'b0;
      if (rel[1:0] < 2'd2) sda = seq_shift[7];
      else drive = 1'b0;
    end else begin
      case (seq_phase)
        SEQ_START_LO, SEQ_RSTART_LO, SEQ_STOP_LO: sda = 1'b0;
        SEQ_RBIT_LO: begin
          scl   = 1'b0;
          drive = 1'b0;
        end
        SEQ_RBIT_HI: drive = 1'b0;
        SEQ_NACK_LO: scl = 1'b0;
        default: ;
      endcase
    end

    r.scl_level   = scl;
    r.sda_level   = drive ? sda : 1'b1;
    r.sda_enable  = drive;
    r.busy_res    = seq_phase != SEQ_IDLE;
    r.done_res    = fin;
    r.read_byte   = rx_byte;
    r.ack_missing = nack_seen;
    return r;
  endfunction

  function automatic void reset_model();
    cfg_tpu         = eba_pkg::TICKS_PER_US_RST;
    cfg_device      = eba_pkg::DEVICE_ADDR_RST;
    cfg_recovery_us = eba_pkg::RECOVERY_US_RST;
    enter_phase(SEQ_IDLE);
    seq_bits  = '0;
    seq_shift = '0;
    lat_op    = 1'b0;
    lat_addr  = '0;
    lat_data  = '0;
    rx_byte   = '0;
    nack_seen = 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random stalls at stall_pct, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        rsp_if.ready <= 1'b0;
        hold_left = hold_left - 1;
      end else if (stall_pct == 0) begin
        rsp_if.ready <= 1'b1;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  task automatic note_field(input string field, input logic [7:0] want,
                            input logic [7:0] got);
    if (want !== got)
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, want, got);
  endtask

  // Compare each rsp transfer with the oldest prediction
  always @(posedge clk) begin : check_lines
    eba_pkg::result_t want;
    eba_pkg::result_t got;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      got = rsp_if.data;
      if (predicted_lines.size() == 0) begin
        mismatches = mismatches + 1;
        $display("%0t ns: unexpected result, expected none, got %h", $time, got);
      end else begin
        want = predicted_lines.pop_front();
        if (want !== got) begin
          mismatches = mismatches + 1;
          note_field("scl_level",   8'(want.scl_level),   8'(got.scl_level));
          note_field("sda_level",   8'(want.sda_level),   8'(got.sda_level));
          note_field("sda_enable",  8'(want.sda_enable),  8'(got.sda_enable));
          note_field("busy_res",    8'(want.busy_res),    8'(got.busy_res));
          note_field("done_res",    8'(want.done_res),    8'(got.done_res));
          note_field("read_byte",   want.read_byte,       got.read_byte);
          note_field("ack_missing", 8'(want.ack_missing), 8'(got.ack_missing));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offer one tick, wait for the transfer, then advance the model. Valid stays high
  // after a transfer so back-to-back ticks never lower and raise it in one step;
  // every pause lowers it first.
  task automatic send_tick(input eba_pkg::item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        cmd_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    cmd_if.valid <= 1'b1;
    cmd_if.data  <= it;
    do @(posedge clk); while (!cmd_if.ready);
    burst_left = burst_left - 1;
    predicted_lines.push_back(predict_lines(it));
    ticks_sent = ticks_sent + 1;
  endtask

  // Hold the sender until every predicted result has come back
  task automatic wait_drained();
    cmd_if.valid <= 1'b0;
    do @(posedge clk); while (predicted_lines.size() != 0);
  endtask

  // Write all three registers once nothing is in flight
  task automatic set_config(input logic [15:0] tpu, input logic [6:0] device,
                            input logic [15:0] recovery);
    wait_drained();
    for (int i = 0; i < 3; i++) begin
      cfg_we <= 1'b1;
      case (i)
        0: begin
          cfg_index <= eba_pkg::CFG_TICKS_PER_US;
          cfg_data  <= tpu;
        end
        1: begin
          cfg_index <= eba_pkg::CFG_DEVICE_ADDR;
          cfg_data  <= {9'd0, device};
        end
        default: begin
          cfg_index <= eba_pkg::CFG_RECOVERY_US;
          cfg_data  <= recovery;
        end
      endcase
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cfg_tpu         = tpu;
    cfg_device      = device;
    cfg_recovery_us = recovery;
  endtask

  // Ticks with no start while idle: random fields, lines must stay idle
  task automatic idle_ticks(input int count);
    eba_pkg::item_t it;
    repeat (count) begin
      it = eba_pkg::item_t'($urandom);
      it.start_request = 1'b0;
      send_tick(it);
    end
  endtask

  // The start tick of one random byte access
  task automatic start_access(input logic op, input logic [7:0] addr,
                              input logic [7:0] data);
    eba_pkg::item_t it;
    it = eba_pkg::item_t'($urandom);
    it.start_request = 1'b1;
    it.operation     = op;
    it.word_address  = addr;
    it.write_data    = data;
    send_tick(it);
  endtask

  // Ticks while the model is busy, at most limit of them.
  // Ack slots see a high level with probability nack_pct; read bits are random.
  task automatic busy_ticks(input int nack_pct, input int limit);
    eba_pkg::item_t it;
    logic [4:0]     rel;
    int             sent;
    sent = 0;
    while (seq_phase != SEQ_IDLE && sent < limit) begin
      it = eba_pkg::item_t'($urandom);
      // a start while busy must be ignored
      it.start_request = ($urandom_range(0, 99) < busy_start_pct);
      rel = seq_phase - SEQ_BYTE0;
      if (in_byte_slot(seq_phase) && rel[1])
        it.sda_in = ($urandom_range(0, 99) < nack_pct);
      send_tick(it);
      sent = sent + 1;
    end
  endtask

  // One full random byte access: the start tick, then ticks until the model is idle
  task automatic run_access(input logic op, input logic [7:0] addr,
                            input logic [7:0] data, input int nack_pct);
    start_access(op, addr, data);
    busy_ticks(nack_pct, ACCESS_LIMIT);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Idle lines after reset, then a read that runs past its first phase at the reset
  // tick rate and finishes at a faster rate written while it is underway
  task automatic test_reset_state();
    stall_pct      = 20;
    gap_max        = 3;
    busy_start_pct = 10;
    idle_ticks(6);
    start_access(OP_READ, 8'hA5, 8'h5A);
    busy_ticks(0, RESET_RATE_TICKS);
    set_config(16'd1, eba_pkg::DEVICE_ADDR_RST, eba_pkg::RECOVERY_US_RST);
    busy_ticks(0, ACCESS_LIMIT);
    idle_ticks(4);
  endtask

  // Register extremes: zero tick rate (treated as one), zero and full recovery,
  // lowest and highest device address, and the slowest tick rate with idle lines.
  // The full recovery is cut short by a smaller value written during it.
  task automatic test_config_extremes();
    stall_pct = 10;
    set_config(16'd0, 7'd0, 16'd0);
    run_access(OP_WRITE, 8'hFF, 8'h00, 0);
    run_access(OP_READ, 8'h00, 8'hFF, 0);
    set_config(16'd1, 7'd127, 16'hFFFF);
    start_access(OP_WRITE, 8'h00, 8'hFF);
    busy_ticks(0, RECOVERY_TICKS);
    set_config(16'd1, 7'd127, 16'd3);
    busy_ticks(0, ACCESS_LIMIT);
    run_access(OP_READ, 8'hFF, 8'h00, 0);
    set_config(16'hFFFF, 7'd127, 16'd0);
    idle_ticks(20);
  endtask

  // Every ack slot high in a write and a read: each must carry on and flag the missing ack; then a clean read
  task automatic test_missing_ack();
    stall_pct = 25;
    set_config(16'd1, 7'($urandom), 16'd3);
    run_access(OP_WRITE, 8'($urandom), 8'($urandom), 100);
    run_access(OP_READ, 8'($urandom), 8'($urandom), 100);
    run_access(OP_READ, 8'($urandom), 8'($urandom), 0);
  endtask

  // Start requests held high on every busy tick must not disturb either access
  task automatic test_start_while_busy();
    busy_start_pct = 100;
    set_config(16'd1, 7'd80, 16'd2);
    run_access(OP_WRITE, 8'h3C, 8'hC3, 0);
    run_access(OP_READ, 8'hC3, 8'h3C, 0);
    busy_start_pct = 10;
  endtask

  // Long receiver hold-off fills the queue and stalls cmd; drain completely, then one read under random stalls and gaps
  task automatic test_back_pressure();
    stall_pct = 0;
    gap_max   = 0;
    set_config(16'd1, 7'($urandom), 16'd5);
    hold_left = LONG_HOLD;
    run_access(OP_READ, 8'($urandom), 8'($urandom), 0);
    run_access(OP_WRITE, 8'($urandom), 8'($urandom), 0);
    wait_drained();
    stall_pct = 50;
    gap_max   = 4;
    run_access(OP_READ, 8'($urandom), 8'($urandom), 20);
  endtask

  // Random accesses over random settings, with idle noise between them
  task automatic test_random_accesses();
    int          first;
    int          nack_pct;
    logic [15:0] tpu;
    first = ticks_sent;
    while (ticks_sent - first < RANDOM_TICKS) begin
      case ($urandom_range(0, 4))
        0:       tpu = 16'd0;
        1, 2:    tpu = 16'd1;
        3:       tpu = 16'd2;
        default: tpu = 16'd3;
      endcase
      set_config(tpu, 7'($urandom_range(0, 127)), 16'($urandom_range(0, 12)));
      case ($urandom_range(0, 3))
        0:       stall_pct = 0;
        1:       stall_pct = 15;
        2:       stall_pct = 40;
        default: stall_pct = 70;
      endcase
      case ($urandom_range(0, 2))
        0:       gap_max = 0;
        1:       gap_max = 2;
        default: gap_max = 6;
      endcase
      busy_start_pct = $urandom_range(0, 30);
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 4))
          0:       nack_pct = 100;
          1:       nack_pct = 25;
          default: nack_pct = 0;
        endcase
        idle_ticks($urandom_range(0, 4));
        run_access(1'($urandom), 8'($urandom), 8'($urandom), nack_pct);
        if (ticks_sent - first >= RANDOM_TICKS) break;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    cmd_if.valid   = 1'b0;
    cmd_if.data    = '0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    burst_left     = 0;
    gap_max        = 0;
    stall_pct      = 0;
    hold_left      = 0;
    busy_start_pct = 0;
    ticks_sent     = 0;
    mismatches     = 0;
    reset_model();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_config_extremes();
    test_missing_ack();
    test_start_while_busy();
    test_back_pressure();
    test_random_accesses();

    // Let the last results out, then keep watching for stray transfers before the final check
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (predicted_lines.size() != 0)
      $display("%0t ns: %0d results never arrived", $time, predicted_lines.size());
    if (mismatches == 0 && predicted_lines.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog for a hung handshake
  initial begin
    #(TIMEOUT_NS);
    $display("%0t ns: timeout", $time);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/eba_pkg.sv
hw/rtl/eba_stream_if.sv
hw/rtl/eba_front.sv
hw/rtl/eba_seq.sv
hw/rtl/i2c_eeprom_byte_access_master.sv
tb/i2c_eeprom_byte_access_master_tb.sv
